// ===== hdl/lmre_pkg.sv =====
// Package: shared types and constants of the linear model row evaluator.
package lmre_pkg;

    // Field widths fixed by the item format.
    localparam int IDX_W  = 8;
    localparam int DATA_W = 32;
    localparam int SUM_W  = 64;

    // Item action codes.
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_BASIS = 1'b1;

    // Output mode codes.
    localparam logic MODE_SHAPE  = 1'b0;
    localparam logic MODE_COLOUR = 1'b1;

    // Limits of the 32-bit result.
    localparam logic signed [DATA_W-1:0] RES_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] RES_MIN = 32'sh8000_0000;

    // Limits of the 64-bit accumulator.
    localparam logic signed [SUM_W-1:0] SUM_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 64'sh8000_0000_0000_0000;

    // One result item.
    typedef struct packed {
        logic signed [DATA_W-1:0] row_value;
        logic                     saturated;
    } t_out_item;

endpackage

// ===== hdl/lmre_in_if.sv =====
// Interface: input item channel with valid/ready handshake.
interface lmre_in_if;
    logic                              valid;
    logic                              ready;
    logic                              action;
    logic [lmre_pkg::IDX_W-1:0]        coef_index;
    logic signed [lmre_pkg::DATA_W-1:0] data_value;
    logic signed [lmre_pkg::DATA_W-1:0] mean_value;
    logic                              first_in_row;
    logic                              last_in_row;

    modport source (
        output valid, action, coef_index, data_value, mean_value,
               first_in_row, last_in_row,
        input  ready
    );

    modport sink (
        input  valid, action, coef_index, data_value, mean_value,
               first_in_row, last_in_row,
        output ready
    );
endinterface

// ===== hdl/lmre_out_if.sv =====
// Interface: result item channel with valid/ready handshake.
interface lmre_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [lmre_pkg::DATA_W-1:0] row_value;
    logic                              saturated;

    modport source (
        output valid, row_value, saturated,
        input  ready
    );

    modport sink (
        input  valid, row_value, saturated,
        output ready
    );
endinterface

// ===== hdl/lmre_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module lmre_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; the data holds while the read enable is low.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/lmre_skid.sv =====
// Output register with a one-item skid stage for the result channel.
module lmre_skid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  lmre_pkg::t_out_item i_item,
    output logic                o_ready,
    output logic                o_valid,
    output lmre_pkg::t_out_item o_item,
    input  logic                i_ready
);

    logic                r_out_valid;
    logic                r_skid_valid;
    lmre_pkg::t_out_item r_out_item;
    lmre_pkg::t_out_item r_skid_item;
    logic                w_out_free;

    // The output register may load when it is empty or being taken.
    assign w_out_free = !r_out_valid || i_ready;
    assign o_ready    = !r_skid_valid;

    // Control: the skid stage fills only when the output register is stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= i_valid;
            end
        end else if (i_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload follows the same moves as the control.
    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_item <= r_skid_item;
            end else if (i_valid) begin
                r_out_item <= i_item;
            end
        end else if (i_valid && !r_skid_valid) begin
            r_skid_item <= i_item;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

endmodule

// ===== hdl/linear_model_row_evaluator_core.sv =====
// Top level: linear model row evaluator, mean plus basis row times coefficients.
//
// Items arrive on i_in (valid/ready). A load item writes data_value into the
// coefficient slot coef_index. A basis item multiplies data_value by the stored
// coefficient at coef_index, shifts the product down by FRAC_BITS and adds it
// to the row sum, which a first element starts from mean_value. A basis item
// with last_in_row set emits one result item on o_out: the row sum in fixed
// point, or in colour mode truncated toward zero to an integer, clipped to 32
// bits with the saturated flag raised when clipped. i_cfg_wr_en writes the
// colour mode bit; the user changes it only while the block is idle, and the block does not enforce it.
// Throughput is one item per cycle while i_in.ready is high. After the edge that
// accepts its last element, a result passes the coefficient RAM read, then the
// multiply, the accumulate and the output register before it appears at o_out.
// The accumulate loop through r_row_sum sets the rate.
// When the receiver stalls, the output register holds its item and one more
// result is caught in a skid stage; only once that is full does i_in.ready fall
// and the whole pipeline freeze. Reset clears the pipeline, the row sum and the
// mode; the coefficient RAM is not cleared and must be loaded before use.
module linear_model_row_evaluator_core #(
    parameter int MAX_COEFS = 256,
    parameter int FRAC_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lmre_in_if.sink    i_in,
    lmre_out_if.source o_out,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data
);

    localparam int ADDR_W = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1;
    localparam logic signed [lmre_pkg::SUM_W-1:0] FRAC_MASK =
        (64'sd1 <<< FRAC_BITS) - 64'sd1;

    // Configuration.
    logic r_color_mode;

    // Front end.
    logic              w_en;
    logic              w_accept;
    logic              w_hit;
    logic [ADDR_W-1:0] w_addr;
    logic              w_wr_en;
    logic [lmre_pkg::DATA_W-1:0] w_rd_data;

    // Stage 1: RAM read in flight.
    logic                               r1_valid;
    logic                               r1_hit;
    logic signed [lmre_pkg::DATA_W-1:0] r1_data;
    logic signed [lmre_pkg::DATA_W-1:0] r1_mean;
    logic                               r1_first;
    logic                               r1_last;
    logic signed [lmre_pkg::DATA_W-1:0] w_coef;

    // Stage 2: product.
    logic                               r2_valid;
    logic signed [lmre_pkg::SUM_W-1:0]  r2_prod;
    logic signed [lmre_pkg::DATA_W-1:0] r2_mean;
    logic                               r2_first;
    logic                               r2_last;

    // Stage 3: accumulator.
    logic signed [lmre_pkg::SUM_W-1:0]  r_row_sum;
    logic signed [lmre_pkg::SUM_W-1:0]  n_row_sum;
    logic                               r3_valid;
    logic signed [lmre_pkg::SUM_W-1:0]  w_scaled;
    logic signed [lmre_pkg::SUM_W-1:0]  w_base;
    logic signed [lmre_pkg::SUM_W:0]    w_sum_ext;

    // Result formatting.
    logic signed [lmre_pkg::SUM_W-1:0]  w_bias;
    logic signed [lmre_pkg::SUM_W-1:0]  w_biased;
    logic signed [lmre_pkg::SUM_W-1:0]  w_mode_val;
    logic                               w_fits;
    lmre_pkg::t_out_item                w_result;
    lmre_pkg::t_out_item                w_out_item;
    logic                               w_out_valid;

    // Colour mode register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode <= lmre_pkg::MODE_SHAPE;
        end else if (i_cfg_wr_en) begin
            r_color_mode <= i_cfg_wr_data;
        end
    end

    // Input handshake and coefficient addressing.
    assign i_in.ready = w_en;
    assign w_accept   = i_in.valid && w_en;
    assign w_hit      = ({24'd0, i_in.coef_index} < 32'(MAX_COEFS));
    assign w_addr     = ADDR_W'(i_in.coef_index);
    assign w_wr_en    = w_accept && (i_in.action == lmre_pkg::ACT_LOAD) && w_hit;

    // Coefficient store.
    lmre_ram #(
        .WIDTH (lmre_pkg::DATA_W),
        .DEPTH (MAX_COEFS)
    ) u_coef_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_addr),
        .i_wr_data (i_in.data_value),
        .i_rd_en   (w_en),
        .i_rd_addr (w_addr),
        .o_rd_data (w_rd_data)
    );

    // Pipeline valid bits; every stage advances together with the enable.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= w_accept && (i_in.action == lmre_pkg::ACT_BASIS);
            r2_valid <= r1_valid;
            r3_valid <= r2_valid && r2_last;
        end
    end

    // Stage 1 payload, captured alongside the RAM read.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_hit   <= w_hit;
            r1_data  <= i_in.data_value;
            r1_mean  <= i_in.mean_value;
            r1_first <= i_in.first_in_row;
            r1_last  <= i_in.last_in_row;
        end
    end

    // Out-of-range slots read as zero.
    assign w_coef = r1_hit ? signed'(w_rd_data) : '0;

    // Stage 2: full 64-bit product of coefficient and basis element.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_prod  <= 64'(w_coef) * 64'(r1_data);
            r2_mean  <= r1_mean;
            r2_first <= r1_first;
            r2_last  <= r1_last;
        end
    end

    // Stage 3: floor-scaled product added with 64-bit saturation.
    assign w_scaled  = r2_prod >>> FRAC_BITS;
    assign w_base    = r2_first ? 64'(r2_mean) : r_row_sum;
    assign w_sum_ext = {w_base[lmre_pkg::SUM_W-1], w_base}
                     + {w_scaled[lmre_pkg::SUM_W-1], w_scaled};

    always_comb begin
        n_row_sum = r_row_sum;
        if (r2_valid) begin
            if (w_sum_ext[lmre_pkg::SUM_W] != w_sum_ext[lmre_pkg::SUM_W-1]) begin
                n_row_sum = w_sum_ext[lmre_pkg::SUM_W] ? lmre_pkg::SUM_MIN
                                                       : lmre_pkg::SUM_MAX;
            end else begin
                n_row_sum = w_sum_ext[lmre_pkg::SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_sum <= '0;
        end else if (w_en) begin
            r_row_sum <= n_row_sum;
        end
    end

    // Result: optional truncation toward zero, then clipping to 32 bits.
    assign w_bias   = (r_row_sum[lmre_pkg::SUM_W-1] && (r_color_mode == lmre_pkg::MODE_COLOUR))
                    ? FRAC_MASK : '0;
    assign w_biased = r_row_sum + w_bias;
    assign w_mode_val = (r_color_mode == lmre_pkg::MODE_COLOUR) ? (w_biased >>> FRAC_BITS)
                                                                : r_row_sum;
    assign w_fits = (&w_mode_val[lmre_pkg::SUM_W-1:lmre_pkg::DATA_W-1])
                 || !(|w_mode_val[lmre_pkg::SUM_W-1:lmre_pkg::DATA_W-1]);

    always_comb begin
        w_result.saturated = !w_fits;
        if (w_fits) begin
            w_result.row_value = w_mode_val[lmre_pkg::DATA_W-1:0];
        end else if (w_mode_val[lmre_pkg::SUM_W-1]) begin
            w_result.row_value = lmre_pkg::RES_MIN;
        end else begin
            w_result.row_value = lmre_pkg::RES_MAX;
        end
    end

    // Output register and skid stage; its free space enables the pipeline.
    lmre_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_valid),
        .i_item  (w_result),
        .o_ready (w_en),
        .o_valid (w_out_valid),
        .o_item  (w_out_item),
        .i_ready (o_out.ready)
    );

    assign o_out.valid     = w_out_valid;
    assign o_out.row_value = w_out_item.row_value;
    assign o_out.saturated = w_out_item.saturated;

endmodule

// ===== hdl/lmre_checker.sv =====
// Checker: port-level assertions for the row evaluator, bound to the top level.
module lmre_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic signed [lmre_pkg::DATA_W-1:0] i_out_row_value,
    input logic                               i_out_saturated
);

    // A stalled result item holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_row_value) && $stable(i_out_saturated))
        else $error("result item changed while stalled");

    // A clipped result sits at one of the 32-bit limits.
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_saturated |->
            (i_out_row_value == lmre_pkg::RES_MAX) || (i_out_row_value == lmre_pkg::RES_MIN))
        else $error("saturated result not at a limit");

    // Reset empties the output side and opens the input.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("reset did not clear the result channel");

    // Input back-pressure only ever follows a waiting result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no result waiting");

endmodule

bind linear_model_row_evaluator_core lmre_checker u_lmre_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_row_value (o_out.row_value),
    .i_out_saturated (o_out.saturated)
);
